>>> hw/rtl/wmf_pkg.sv
// Package: shared types and constants of the window median filter.
package wmf_pkg;

   localparam int PIX_W = 8;
   localparam int MAX_CH = 4;
   localparam int CFG_W = 11;
   localparam int CNT_W = 13;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_CHANS  = 2'd2;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;
   localparam logic [2:0]       RESET_CHANS  = 3'd3;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic valid;
      logic last;
   } lane_ctl_type;

endpackage

>>> hw/rtl/wmf_lane.sv
// Median lane: pipelined median of one channel over a square window.
module wmf_lane #(
   parameter int AREA = 9
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [AREA*wmf_pkg::PIX_W-1:0] win,
   output wmf_pkg::pix_type               med
);
   localparam int PW = wmf_pkg::PIX_W;
   localparam int STAGES = AREA;
   logic [AREA*PW-1:0] stg_ff [STAGES+1];
   logic [AREA*PW-1:0] stg_in [STAGES];

   // Odd-even transposition sort, one pass per stage.
   always_comb begin
      for (int s = 0; s < STAGES; s++) begin
         stg_in[s] = stg_ff[s];
         for (int i = s % 2; i + 1 < AREA; i += 2) begin
            if (stg_ff[s][i*PW +: PW] > stg_ff[s][(i+1)*PW +: PW]) begin
               stg_in[s][i*PW +: PW]     = stg_ff[s][(i+1)*PW +: PW];
               stg_in[s][(i+1)*PW +: PW] = stg_ff[s][i*PW +: PW];
            end
         end
      end
   end

   // All stages hold together while the enable is low.
   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff[0] <= win;
         for (int s = 0; s < STAGES; s++) begin
            stg_ff[s+1] <= stg_in[s];
         end
      end
   end

   assign med = stg_ff[STAGES][(AREA/2)*PW +: PW];
endmodule

>>> hw/rtl/window_median_filter_core.sv
// Top level: streaming median filter with line store, window and lanes.
//
// Pixels enter on the req_ channel in raster order, one transaction per
// clock unless the pipeline holds. req_tuser is the mode: 0 a pixel, 1 a
// drain tick after the frame. Once the input runs RADIUS rows plus RADIUS
// pixels ahead of the output position, each accepted transaction gives a
// result on rsp_: the median of every enabled channel over the window,
// with rsp_tlast marking the last pixel of the frame. Drain ticks flush
// the tail of the frame. Edges replicate the nearest pixel. Throughput is
// one transaction per cycle unless the pipeline holds; a result passes the
// line store read register, the lane input register and AREA sorting passes.
// The line store keeps SIDE+1 rows, rounded up to a power of two, and each
// row memory is copied once per window column so that every copy is read
// at a single address per cycle; a write to the address being read is
// passed straight through. When rsp_tready is low while a result waits,
// the whole pipeline holds and req_tready drops in the same cycle.
// Reset clears counters and valid flags and loads the register reset
// values; line storage is not cleared.
module window_median_filter_core #(
   parameter int WINDOW_SIZE  = 3,
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_HEIGHT   = 1024,
   parameter int MAX_CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // in_c0, in_c1, in_c2, in_c3
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // med_c0, med_c1, med_c2, med_c3
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata
);
   localparam int RADIUS = WINDOW_SIZE / 2;
   localparam int SIDE = 2 * RADIUS + 1;
   localparam int AREA = SIDE * SIDE;
   localparam int ROWS = 2 ** $clog2(SIDE + 1);
   localparam int PW = wmf_pkg::PIX_W;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int RI = $clog2(ROWS);
   localparam int LAT = AREA + 1;
   localparam int PSW = CW + RW + 2;

   logic [10:0] width_ff, height_ff;
   logic [2:0]  chans_ff;
   logic [CW:0] fw_ff;
   logic [RW:0] fh_ff;
   logic [CW:0] in_col_ff, out_col_ff;
   logic [RW:0] in_row_ff, out_row_ff;
   logic [RI-1:0] in_slot_ff;
   logic [PSW-1:0] pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= wmf_pkg::RESET_WIDTH;
         height_ff <= wmf_pkg::RESET_HEIGHT;
         chans_ff <= wmf_pkg::RESET_CHANS;
      end else if (csr_we) begin
         case (csr_addr)
            wmf_pkg::REG_WIDTH:  width_ff <= csr_wdata;
            wmf_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            wmf_pkg::REG_CHANS:  chans_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Pipeline advances when the output stage can take data.
   logic adv;
   logic [LAT:0] v_ff;
   assign adv = !v_ff[LAT] || rsp_tready;
   assign req_tready = adv;
   logic acc;
   assign acc = req_tvalid && adv;

   logic [CW:0] fw_cur;
   logic [RW:0] fh_cur;
   logic start;
   assign start = (in_row_ff == '0) && (in_col_ff == '0);
   always_comb begin
      if (width_ff == '0) fw_cur = (CW+1)'(1);
      else if (13'(width_ff) > 13'(MAX_WIDTH)) fw_cur = (CW+1)'(MAX_WIDTH);
      else fw_cur = (CW+1)'(width_ff);
      if (height_ff == '0) fh_cur = (RW+1)'(1);
      else if (13'(height_ff) > 13'(MAX_HEIGHT)) fh_cur = (RW+1)'(MAX_HEIGHT);
      else fh_cur = (RW+1)'(height_ff);
   end
   logic [CW:0] fw;
   logic [RW:0] fh;
   assign fw = start ? fw_cur : fw_ff;
   assign fh = start ? fh_cur : fh_ff;

   logic taking, wr, emit, fr_last;
   assign taking = in_row_ff < fh;
   assign wr = acc && taking && !req_tuser;
   // Output due once the input position is RADIUS rows plus RADIUS pixels
   // past the frame start; pos_ff counts the input positions consumed.
   logic [PSW-1:0] lag;
   assign lag = PSW'(RADIUS) * PSW'(fw) + PSW'(RADIUS);
   logic ahead;
   assign ahead = pos_ff >= lag;
   logic go;
   assign go = acc && (!taking || !req_tuser);
   assign emit = go && ahead;
   logic [CW:0] oc_nx;
   logic [RW:0] or_nx;
   always_comb begin
      oc_nx = out_col_ff + 1'b1;
      or_nx = out_row_ff;
      if (oc_nx >= fw) begin
         oc_nx = '0;
         or_nx = out_row_ff + 1'b1;
      end
   end
   assign fr_last = or_nx >= fh;

   // Window taps: rows and columns around the output position, clamped
   // to the frame so that edge pixels are replicated.
   logic [RI-1:0] slot_of [SIDE];
   logic [CW-1:0] col_of [SIDE];
   logic [RW:0] rr;
   logic [CW:0] cc;
   always_comb begin
      for (int d = 0; d < SIDE; d++) begin
         rr = out_row_ff + (RW+1)'(d);
         if (rr < (RW+1)'(RADIUS)) rr = '0;
         else rr = rr - (RW+1)'(RADIUS);
         if (rr >= fh) rr = fh - 1'b1;
         slot_of[d] = RI'(rr % ROWS);
         cc = out_col_ff + (CW+1)'(d);
         if (cc < (CW+1)'(RADIUS)) cc = '0;
         else cc = cc - (CW+1)'(RADIUS);
         if (cc >= fw) cc = fw - 1'b1;
         col_of[d] = cc[CW-1:0];
      end
   end

   // Line store: one memory per row slot and window column. The newest
   // pixel of the window is written in the same cycle it is needed, so a
   // read of the address being written returns the incoming pixel.
   logic [31:0] q_ff [ROWS][SIDE];
   logic [RI-1:0] slot_ff [SIDE];
   for (genvar r = 0; r < ROWS; r++) begin : g_row
      for (genvar t = 0; t < SIDE; t++) begin : g_tap
         logic [31:0] mem [MAX_WIDTH];
         always_ff @(posedge clock) begin
            if (wr && in_slot_ff == RI'(r)) mem[in_col_ff[CW-1:0]] <= req_tdata;
            if (adv) begin
               if (wr && in_slot_ff == RI'(r) && in_col_ff[CW-1:0] == col_of[t]) begin
                  q_ff[r][t] <= req_tdata;
               end else begin
                  q_ff[r][t] <= mem[col_of[t]];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int y = 0; y < SIDE; y++) slot_ff[y] <= slot_of[y];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0; out_row_ff <= '0;
         in_slot_ff <= '0; fw_ff <= '0; fh_ff <= '0; pos_ff <= '0;
      end else if (go) begin
         fw_ff <= fw; fh_ff <= fh;
         if (emit && fr_last) begin
            in_col_ff <= '0; in_row_ff <= '0; out_col_ff <= '0;
            out_row_ff <= '0; in_slot_ff <= '0; pos_ff <= '0;
         end else begin
            pos_ff <= pos_ff + 1'b1;
            if (in_col_ff + 1'b1 >= fw) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + 1'b1;
               in_slot_ff <= (in_slot_ff == RI'(ROWS-1)) ? '0 : in_slot_ff + 1'b1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
            if (emit) begin
               out_col_ff <= oc_nx; out_row_ff <= or_nx;
            end
         end
      end
   end

   // Lanes hold their contents while stalled through their enable.
   wmf_pkg::pix_type med [MAX_CHANNELS];
   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      logic [AREA*PW-1:0] lane_win;
      always_comb begin
         for (int y = 0; y < SIDE; y++)
            for (int x = 0; x < SIDE; x++)
               lane_win[(y*SIDE+x)*PW +: PW] = q_ff[slot_ff[y]][x][c*PW +: PW];
      end
      wmf_lane #(.AREA(AREA)) u_lane (
         .clock(clock), .en(adv), .win(lane_win), .med(med[c]));
   end

   wmf_pkg::lane_ctl_type ctl_ff [LAT+1];
   logic [2:0] ch_ff [LAT+1];
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAT-1:0], emit};
      end
      if (adv) begin
         ctl_ff[0] <= '{valid: emit, last: fr_last};
         ch_ff[0] <= chans_ff;
         for (int s = 0; s < LAT; s++) begin
            ctl_ff[s+1] <= ctl_ff[s];
            ch_ff[s+1] <= ch_ff[s];
         end
      end
   end

   assign rsp_tvalid = v_ff[LAT];
   assign rsp_tlast = ctl_ff[LAT].last;
   always_comb begin
      rsp_tdata = '0;
      for (int c = 0; c < MAX_CHANNELS; c++)
         if (3'(c) < ch_ff[LAT]) rsp_tdata[c*PW +: PW] = med[c];
   end

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result lost");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready) else $error("accept in stall");
   a_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ctl_ff[LAT].valid) else $error("control mismatch");
`endif
endmodule

>>> tb/sv/tb_top.sv
// Testbench for window_median_filter_core: random frames checked against a median predictor.
module tb_top;

   // Pixel store geometry used by the predictor: a 3x3 window keeps four rows.
   localparam int RAD       = 1;
   localparam int SIDE      = 2 * RAD + 1;
   localparam int ROWS_HELD = SIDE + 1;
   localparam int WMAX      = 1024;
   localparam int HMAX      = 1024;
   localparam int WD_LIMIT  = 3000;
   localparam int HOLD_LEN  = 400;

   // One input transaction: a drain tick or a pixel of four channel bytes.
   typedef struct {
      bit          drain;
      logic [31:0] pix;
   } pixel_item_type;

   // One expected output transaction.
   typedef struct packed {
      logic [31:0] med;
      logic        frame_end;
   } median_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // in_c0, in_c1, in_c2, in_c3
   logic        req_tuser = 1'b0; // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // med_c0, med_c1, med_c2, med_c3
   logic        rsp_tlast;        // frame_end
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = wmf_pkg::REG_WIDTH;
   logic [10:0] csr_wdata = '0;

   window_median_filter_core uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Pending input items, and the medians still owed by the block.
   pixel_item_type    pixel_queue[$];
   median_result_type median_queue[$];

   int  error_count = 0;
   bit  quiet = 1'b0;     // no idling on either side once set
   bit  hold_req = 1'b0;  // asks the receiver for one long hold-off
   int  idle_cycles = 0;

   // Predictor state: configuration, row store and the in/out raster counters.
   logic [10:0] cfg_width  = wmf_pkg::RESET_WIDTH;
   logic [10:0] cfg_height = wmf_pkg::RESET_HEIGHT;
   logic [2:0]  cfg_chans  = wmf_pkg::RESET_CHANS;
   logic [31:0] row_mem[ROWS_HELD][WMAX];
   int unsigned col_in = 0, row_in = 0, col_out = 0, row_out = 0;
   int unsigned fw = wmf_pkg::RESET_WIDTH, fh = wmf_pkg::RESET_HEIGHT;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned mx);
      if (v == 0) return 1;
      return (v > mx) ? mx : v;
   endfunction

   function automatic int unsigned clamp_at(int v, int unsigned n);
      if (v < 0) return 0;
      if (v >= int'(n)) return n - 1;
      return v;
   endfunction

   // Advances the predictor by one accepted transaction and queues the
   // resulting median, if the window has reached a valid output position.
   task automatic filter_step(input bit drain, input logic [31:0] pix);
      int unsigned       pos, lag, r, c, chans, k;
      logic [31:0]       win[SIDE*SIDE];
      logic [7:0]        vals[SIDE*SIDE];
      logic [7:0]        tmp;
      median_result_type res;

      // Frame size is latched at the first pixel of each frame.
      if (row_in == 0 && col_in == 0) begin
         fw = clamp_dim(cfg_width, WMAX);
         fh = clamp_dim(cfg_height, HMAX);
      end
      if (row_in < fh) begin
         // A drain tick while the frame still takes pixels is ignored.
         if (drain) return;
         row_mem[row_in % ROWS_HELD][col_in] = pix;
      end
      // Past the last row, pixels and drain ticks alike flush the tail.
      pos = row_in * fw + col_in;
      col_in++;
      if (col_in >= fw) begin
         col_in = 0;
         row_in++;
      end
      lag = RAD * fw + RAD;
      if (pos < lag) return;

      // Edge pixels are replicated outside the image, corners included.
      k = 0;
      for (int dy = -RAD; dy <= RAD; dy++) begin
         r = clamp_at(int'(row_out) + dy, fh);
         for (int dx = -RAD; dx <= RAD; dx++) begin
            c = clamp_at(int'(col_out) + dx, fw);
            win[k] = row_mem[r % ROWS_HELD][c];
            k++;
         end
      end
      chans = (cfg_chans > wmf_pkg::MAX_CH) ? wmf_pkg::MAX_CH : cfg_chans;
      res.med = '0;
      for (int ch = 0; ch < wmf_pkg::MAX_CH; ch++) begin
         if (ch < chans) begin
            for (int i = 0; i < SIDE*SIDE; i++) vals[i] = win[i][ch*8 +: 8];
            for (int i = 0; i < SIDE*SIDE; i++)
               for (int j = 0; j < SIDE*SIDE - 1 - i; j++)
                  if (vals[j] > vals[j+1]) begin
                     tmp = vals[j];
                     vals[j] = vals[j+1];
                     vals[j+1] = tmp;
                  end
            res.med[ch*8 +: 8] = vals[(SIDE*SIDE)/2];
         end
      end
      col_out++;
      if (col_out >= fw) begin
         col_out = 0;
         row_out++;
      end
      res.frame_end = 1'b0;
      if (row_out >= fh) begin
         res.frame_end = 1'b1;
         col_in = 0;
         row_in = 0;
         col_out = 0;
         row_out = 0;
      end
      median_queue = {median_queue, res};
   endtask

   // Driver: presents queued items, inserting random bursts of idle cycles.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) filter_step(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pixel_queue.size() > 0 && !quiet && $urandom_range(0, 19) == 0) begin
               gap_left = $urandom_range(0, 8);
               req_tvalid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               pixel_item_type it;
               it = pixel_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= it.pix;
               req_tuser  <= it.drain;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request so
   // that the pipeline fills and the block stalls its input.
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: every accepted result is checked against the oldest median owed.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (median_queue.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result transaction: data %h last %b",
                        rsp_tdata, rsp_tlast);
         end else begin
            median_result_type want;
            want = median_queue.pop_front();
            for (int ch = 0; ch < wmf_pkg::MAX_CH; ch++) begin
               if (rsp_tdata[ch*8 +: 8] !== want.med[ch*8 +: 8]) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("med_c%0d mismatch: expected %h actual %h",
                              ch, want.med[ch*8 +: 8], rsp_tdata[ch*8 +: 8]);
               end
            end
            if (rsp_tlast !== want.frame_end) begin
               error_count++;
               if (error_count <= 10)
                  $display("frame_end mismatch: expected %b actual %b",
                           want.frame_end, rsp_tlast);
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Waits until every queued item is taken and every median has arrived,
   // then lets the sorting pipeline settle so ignored items cannot linger.
   task automatic wait_idle();
      wait (pixel_queue.size() == 0 && !req_tvalid && median_queue.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         wmf_pkg::REG_WIDTH:  cfg_width  = val;
         wmf_pkg::REG_HEIGHT: cfg_height = val;
         wmf_pkg::REG_CHANS:  cfg_chans  = val[2:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] make_pixel(int pattern);
      logic [31:0] p;
      case (pattern)
         1: p = 32'h0000_0000;
         2: p = 32'hffff_ffff;
         3: for (int b = 0; b < 4; b++) p[b*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
         default: p = $urandom;
      endcase
      return p;
   endfunction

   // Configures the block and queues one full frame plus its flush tail.
   // Pattern 4 steps through patterns 0 to 3 in turn; noise sprinkles drain
   // ticks inside the frame, which the block must ignore.
   task automatic run_frame(input int w, input int h, input int ch, input int pattern,
                            input int noise_pct);
      int unsigned ew, eh;
      pixel_item_type it;
      wait_idle();
      write_reg(wmf_pkg::REG_WIDTH, w[10:0]);
      write_reg(wmf_pkg::REG_HEIGHT, h[10:0]);
      write_reg(wmf_pkg::REG_CHANS, ch[10:0]);
      ew = clamp_dim(w[10:0], WMAX);
      eh = clamp_dim(h[10:0], HMAX);
      for (int i = 0; i < ew * eh; i++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            it.drain = 1'b1;
            it.pix   = $urandom;
            pixel_queue = {pixel_queue, it};
         end
         it.drain = 1'b0;
         it.pix   = make_pixel(pattern == 4 ? i % 4 : pattern);
         pixel_queue = {pixel_queue, it};
      end
      // The tail: mostly drain ticks, some stray pixels that act as drains.
      for (int i = 0; i < RAD * ew + RAD; i++) begin
         it.drain = ($urandom_range(0, 3) != 0);
         it.pix   = $urandom;
         pixel_queue = {pixel_queue, it};
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed frames: byte extremes, degenerate sizes, channel counts
      // of zero and above the maximum, and ignored drain ticks.
      run_frame(3, 3, 4, 4, 0);
      run_frame(0, 0, 0, 0, 0);
      run_frame(1, 3, 7, 3, 0);
      run_frame(4, 1, 2, 0, 30);

      // A long receiver hold-off while a frame streams in.
      wait_idle();
      hold_req = 1'b1;
      run_frame(10, 8, 4, 0, 5);

      // Random small frames with random content and channel counts.
      for (int f = 0; f < 4; f++)
         run_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7),
                   $urandom_range(0, 3), $urandom_range(0, 10));

      // Tallest frame: a height register above the maximum saturates.
      run_frame(1, 2047, 1, 0, 0);

      // Last part without idling on either side.
      wait_idle();
      quiet = 1'b1;
      for (int f = 0; f < 3; f++)
         run_frame($urandom_range(1, 9), $urandom_range(1, 6), $urandom_range(1, 4), 0, 5);

      wait_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
